// ----- sv/plnpt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package plnpt_pkg;

    localparam int CORDIC_STEPS = 20;
    localparam int ZW           = 25;
    localparam int DEG180       = 2949120;
    localparam int HEAD_MAX     = 23040;
    localparam int HEAD_EAST    = 11520;
    localparam int HEAD_NORTH   = 17280;
    localparam int HEAD_SOUTH   = 5760;
    localparam int HEAD_W       = 15;
    localparam int IDX_OUT_W    = 12;
    localparam int HINT_W       = 13;
    localparam int WIN_W        = 12;

    typedef struct packed {
        logic take;
        logic bwd_start;
        logic rd_best;
        logic rd_next;
        logic cap_next;
        logic cord_init;
        logic cord_step;
        logic load_result;
    } plnpt_cmd_t;

    typedef struct packed {
        logic req_query;
        logic query_err;
        logic full_scan;
        logic scan_busy;
        logic cord_last;
        logic out_free;
    } plnpt_stat_t;

    // arctan(2^-i) in 2^-14 degree
    function automatic logic [19:0] atan_lut(input logic [4:0] i);
        logic [19:0] r;
        begin
            unique case (i)
                5'd0:    r = 20'd737280;
                5'd1:    r = 20'd435242;
                5'd2:    r = 20'd229970;
                5'd3:    r = 20'd116736;
                5'd4:    r = 20'd58595;
                5'd5:    r = 20'd29326;
                5'd6:    r = 20'd14667;
                5'd7:    r = 20'd7334;
                5'd8:    r = 20'd3667;
                5'd9:    r = 20'd1833;
                5'd10:   r = 20'd917;
                5'd11:   r = 20'd458;
                5'd12:   r = 20'd229;
                5'd13:   r = 20'd115;
                5'd14:   r = 20'd57;
                5'd15:   r = 20'd29;
                5'd16:   r = 20'd14;
                5'd17:   r = 20'd7;
                5'd18:   r = 20'd4;
                5'd19:   r = 20'd2;
                default: r = 20'd0;
            endcase
            return r;
        end
    endfunction

endpackage
`default_nettype wire

// ----- sv/plnpt_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
module plnpt_ram #(
    parameter int WIDTH = 72,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

// ----- sv/plnpt_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
module plnpt_ctrl
    import plnpt_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire plnpt_stat_t st,
    output plnpt_cmd_t       cmd
);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_FWD   = 9'b000000010,
        S_BWD   = 9'b000000100,
        S_RDB   = 9'b000001000,
        S_RDN   = 9'b000010000,
        S_RDW   = 9'b000100000,
        S_CINIT = 9'b001000000,
        S_CORD  = 9'b010000000,
        S_DONE  = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    assign s_tready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.take = s_tvalid;
                if (s_tvalid && st.req_query)
                begin
                    state_next = st.query_err ? S_DONE : S_FWD;
                end
            end
            S_FWD:
            begin
                if (!st.scan_busy)
                begin
                    if (st.full_scan)
                    begin
                        state_next = S_RDB;
                    end
                    else
                    begin
                        cmd.bwd_start = 1'b1;
                        state_next    = S_BWD;
                    end
                end
            end
            S_BWD:
            begin
                if (!st.scan_busy)
                begin
                    state_next = S_RDB;
                end
            end
            S_RDB:
            begin
                cmd.rd_best = 1'b1;
                state_next  = S_RDN;
            end
            S_RDN:
            begin
                cmd.rd_next = 1'b1;
                state_next  = S_RDW;
            end
            S_RDW:
            begin
                cmd.cap_next = 1'b1;
                state_next   = S_CINIT;
            end
            S_CINIT:
            begin
                cmd.cord_init = 1'b1;
                state_next    = S_CORD;
            end
            S_CORD:
            begin
                cmd.cord_step = 1'b1;
                if (st.cord_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (st.out_free)
                begin
                    cmd.load_result = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_result |-> st.out_free)
        else $error("result loaded over a pending transfer");

    a_err_done: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.take && st.req_query && st.query_err) |=> (state_reg == S_DONE))
        else $error("bad query did not go straight to result");

    a_bwd_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.bwd_start |-> (!st.scan_busy && !st.full_scan))
        else $error("backward scan started while forward scan busy");

endmodule
`default_nettype wire

// ----- sv/plnpt_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
module plnpt_dp
    import plnpt_pkg::*;
#(
    parameter int MAX_POINTS  = 4096,
    parameter int COORD_WIDTH = 24
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     req_type,
    input  wire logic                     restart_table,
    input  wire logic [COORD_WIDTH-1:0]   coord_x,
    input  wire logic [COORD_WIDTH-1:0]   coord_y,
    input  wire logic [COORD_WIDTH-1:0]   coord_z,
    input  wire logic [HINT_W-1:0]        hint_index,
    input  wire logic [WIN_W-1:0]         window_steps,
    input  wire plnpt_cmd_t               cmd,
    output plnpt_stat_t                   st,
    input  wire logic                     m_tready,
    output logic                          m_tvalid,
    output logic [IDX_OUT_W-1:0]          nearest_index,
    output logic [HEAD_W-1:0]             heading,
    output logic [COORD_WIDTH-1:0]        near_x,
    output logic [COORD_WIDTH-1:0]        near_y,
    output logic [COORD_WIDTH-1:0]        near_z,
    output logic                          query_error
);

    localparam int CW   = COORD_WIDTH;
    localparam int AW   = $clog2(MAX_POINTS);
    localparam int CNTW = AW + 1;
    localparam int DW   = CW + 1;
    localparam int SQW  = 2 * DW - 1;
    localparam int SUMW = SQW + 2;
    localparam int XW   = CW + 23;

    // point store
    logic            wr_en, rd_en;
    logic [AW-1:0]   wr_addr, rd_addr;
    logic [3*CW-1:0] rd_data;

    plnpt_ram #(.WIDTH(3 * CW), .DEPTH(MAX_POINTS)) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data ({coord_z, coord_y, coord_x}),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    logic [CNTW-1:0] count_reg, count_next;
    logic            take_append, take_query;
    logic            table_full;

    assign take_append = cmd.take && !req_type;
    assign take_query  = cmd.take && req_type;
    assign table_full  = (32'(count_reg) >= 32'(MAX_POINTS));
    assign wr_en       = take_append && (restart_table || !table_full);
    assign wr_addr     = restart_table ? '0 : count_reg[AW-1:0];

    always_comb
    begin
        count_next = count_reg;
        if (take_append)
        begin
            if (restart_table)
            begin
                count_next = CNTW'(1);
            end
            else if (!table_full)
            begin
                count_next = count_reg + CNTW'(1);
            end
        end
    end

    // query decode
    logic        full_hint, qerr;
    logic [31:0] fwd_end;

    assign full_hint = (hint_index == {HINT_W{1'b1}});
    assign qerr = (count_reg == '0)
               || (hint_index[HINT_W-1] && !full_hint)
               || (!hint_index[HINT_W-1] && (32'(hint_index[HINT_W-2:0]) >= 32'(count_reg)));
    assign fwd_end = 32'(hint_index[HINT_W-2:0]) + 32'(window_steps);

    logic [CW-1:0]    qx_reg, qy_reg, qz_reg;
    logic [WIN_W-1:0] win_reg;
    logic             full_reg, err_reg;
    logic [CNTW-1:0]  addr_reg, end_reg;
    logic [AW-1:0]    best_reg;
    logic [SUMW-1:0]  best_d_reg;
    logic             have_reg;

    // scan pipeline: read, difference, square, sum, compare
    logic                  issue;
    logic                  v1_reg, v2_reg, v3_reg, v4_reg;
    logic [AW-1:0]         i1_reg, i2_reg, i3_reg, i4_reg;
    logic signed [DW-1:0]  dx_s_reg, dy_s_reg, dz_s_reg;
    logic [SQW-1:0]        sqx_reg, sqy_reg, sqz_reg;
    logic [SUMW-1:0]       sum_reg;
    logic                  better;
    logic [AW-1:0]         next_idx;
    logic [31:0]           bwd_lo;

    assign issue  = (addr_reg < end_reg);
    assign better = v4_reg && (!have_reg || (sum_reg < best_d_reg));
    assign next_idx = ((32'(best_reg) + 32'd1) >= 32'(count_reg)) ? '0 : best_reg + AW'(1);
    assign bwd_lo = (32'(best_reg) > 32'(win_reg)) ? (32'(best_reg) - 32'(win_reg)) : 32'd0;

    assign rd_en   = issue || cmd.rd_best || cmd.rd_next;
    assign rd_addr = cmd.rd_best ? best_reg : (cmd.rd_next ? next_idx : addr_reg[AW-1:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            addr_reg  <= '0;
            end_reg   <= '0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            v4_reg    <= 1'b0;
            have_reg  <= 1'b0;
            full_reg  <= 1'b0;
            err_reg   <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            v1_reg    <= issue;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            v4_reg    <= v3_reg;
            if (take_query)
            begin
                err_reg  <= qerr;
                full_reg <= full_hint;
                have_reg <= 1'b0;
                if (!qerr)
                begin
                    if (full_hint)
                    begin
                        addr_reg <= '0;
                        end_reg  <= count_reg;
                    end
                    else
                    begin
                        addr_reg <= CNTW'(hint_index[HINT_W-2:0]);
                        end_reg  <= (fwd_end > 32'(count_reg)) ? count_reg : CNTW'(fwd_end);
                    end
                end
            end
            else if (cmd.bwd_start)
            begin
                addr_reg <= CNTW'(bwd_lo);
                end_reg  <= CNTW'(best_reg);
            end
            else
            begin
                if (issue)
                begin
                    addr_reg <= addr_reg + CNTW'(1);
                end
                if (better)
                begin
                    have_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_query)
        begin
            qx_reg   <= coord_x;
            qy_reg   <= coord_y;
            qz_reg   <= coord_z;
            win_reg  <= window_steps;
            best_reg <= full_hint ? '0 : AW'(hint_index[HINT_W-2:0]);
        end
        else if (better)
        begin
            best_reg   <= i4_reg;
            best_d_reg <= sum_reg;
        end
        i1_reg   <= addr_reg[AW-1:0];
        i2_reg   <= i1_reg;
        i3_reg   <= i2_reg;
        i4_reg   <= i3_reg;
        dx_s_reg <= DW'($signed(rd_data[CW-1:0]))      - DW'($signed(qx_reg));
        dy_s_reg <= DW'($signed(rd_data[2*CW-1:CW]))   - DW'($signed(qy_reg));
        dz_s_reg <= DW'($signed(rd_data[3*CW-1:2*CW])) - DW'($signed(qz_reg));
        sqx_reg  <= SQW'(dx_s_reg * dx_s_reg);
        sqy_reg  <= SQW'(dy_s_reg * dy_s_reg);
        sqz_reg  <= SQW'(dz_s_reg * dz_s_reg);
        sum_reg  <= SUMW'(sqx_reg) + SUMW'(sqy_reg) + SUMW'(sqz_reg);
    end

    // heading: fetch best and next point, then CORDIC vectoring
    logic [CW-1:0]         bx_reg, by_reg, bz_reg;
    logic signed [DW-1:0]  hdx_reg, hdz_reg;
    logic signed [XW-1:0]  cx_reg, cy_reg;
    logic signed [ZW-1:0]  cz_reg;
    logic [4:0]            iter_reg;
    logic                  spec_reg;
    logic [HEAD_W-1:0]     spec_head_reg;
    logic signed [XW-1:0]  cx_sh, cy_sh;
    logic signed [ZW-1:0]  ang;
    logic signed [ZW-1:0]  hv, hr;
    logic [HEAD_W-1:0]     head_val;

    assign cx_sh = cx_reg >>> iter_reg;
    assign cy_sh = cy_reg >>> iter_reg;
    assign ang   = ZW'($signed({1'b0, atan_lut(iter_reg)}));
    assign hv    = cz_reg + ZW'(DEG180);
    assign hr    = (hv + ZW'(128)) >>> 8;

    always_comb
    begin
        if (spec_reg)
        begin
            head_val = spec_head_reg;
        end
        else if (hv < 0)
        begin
            head_val = '0;
        end
        else if (hr > ZW'(HEAD_MAX))
        begin
            head_val = HEAD_W'(HEAD_MAX);
        end
        else
        begin
            head_val = HEAD_W'(hr);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_next)
        begin
            bx_reg <= rd_data[CW-1:0];
            by_reg <= rd_data[2*CW-1:CW];
            bz_reg <= rd_data[3*CW-1:2*CW];
        end
        if (cmd.cap_next)
        begin
            hdx_reg <= DW'($signed(rd_data[CW-1:0]))      - DW'($signed(bx_reg));
            hdz_reg <= DW'($signed(rd_data[3*CW-1:2*CW])) - DW'($signed(bz_reg));
        end
        if (cmd.cord_init)
        begin
            iter_reg <= '0;
            spec_reg <= (hdx_reg == 0) || (hdz_reg == 0);
            if (hdz_reg == 0)
            begin
                spec_head_reg <= (hdx_reg < 0) ? HEAD_W'(HEAD_MAX) : HEAD_W'(HEAD_EAST);
            end
            else
            begin
                spec_head_reg <= (hdz_reg > 0) ? HEAD_W'(HEAD_NORTH) : HEAD_W'(HEAD_SOUTH);
            end
            if (hdx_reg < 0)
            begin
                cx_reg <= XW'(-hdx_reg) <<< 20;
                cy_reg <= XW'(-hdz_reg) <<< 20;
                cz_reg <= (hdz_reg > 0) ? ZW'(DEG180) : -ZW'(DEG180);
            end
            else
            begin
                cx_reg <= XW'(hdx_reg) <<< 20;
                cy_reg <= XW'(hdz_reg) <<< 20;
                cz_reg <= '0;
            end
        end
        else if (cmd.cord_step)
        begin
            iter_reg <= iter_reg + 5'd1;
            if (cy_reg > 0)
            begin
                cx_reg <= cx_reg + cy_sh;
                cy_reg <= cy_reg - cx_sh;
                cz_reg <= cz_reg + ang;
            end
            else
            begin
                cx_reg <= cx_reg - cy_sh;
                cy_reg <= cy_reg + cx_sh;
                cz_reg <= cz_reg - ang;
            end
        end
    end

    // result register
    logic m_tvalid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (cmd.load_result)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_result)
        begin
            query_error <= err_reg;
            if (err_reg)
            begin
                nearest_index <= '0;
                heading       <= '0;
                near_x        <= '0;
                near_y        <= '0;
                near_z        <= '0;
            end
            else
            begin
                nearest_index <= IDX_OUT_W'(best_reg);
                heading       <= head_val;
                near_x        <= bx_reg;
                near_y        <= by_reg;
                near_z        <= bz_reg;
            end
        end
    end

    assign m_tvalid     = m_tvalid_reg;
    assign st.req_query = req_type;
    assign st.query_err = qerr;
    assign st.full_scan = full_reg;
    assign st.scan_busy = issue || v1_reg || v2_reg || v3_reg || v4_reg;
    assign st.cord_last = (iter_reg == 5'(CORDIC_STEPS - 1));
    assign st.out_free  = !m_tvalid_reg || m_tready;

endmodule
`default_nettype wire

// ----- sv/polyline_nearest_point_tracker_top.sv -----
// Append: stores the point (dropped when the table is full and restart_table is low) and is ready again at once.
// Query: a full scan reads the whole table; a windowed search reads the forward window,
// then the backward window that ends at the best point so far; a rejected query goes
// straight to the result. Points are read one per cycle; after the scan, two point reads
// and a 20-step CORDIC follow. Input is ready again the cycle after the result loads.
// Reset (rst_n low, asynchronous) empties the table; stored points are undefined.
`timescale 1ns / 1ps
`default_nettype none
module polyline_nearest_point_tracker_top
    import plnpt_pkg::*;
#(
    parameter int MAX_POINTS  = 4096,
    parameter int COORD_WIDTH = 24
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic s_tvalid,
    output logic      s_tready,
    // coord_x, coord_y, coord_z, hint_index, window_steps, zero pad
    input  wire logic [((3*COORD_WIDTH+25+7)/8)*8-1:0] s_tdata,
    // req_type, restart_table
    input  wire logic [1:0] s_tuser,
    output logic      m_tvalid,
    input  wire logic m_tready,
    // nearest_index, heading, near_x, near_y, near_z, zero pad
    output logic [((3*COORD_WIDTH+27+7)/8)*8-1:0] m_tdata,
    // query_error
    output logic [0:0] m_tuser
);

    localparam int CW  = COORD_WIDTH;
    localparam int MDW = ((3 * CW + 27 + 7) / 8) * 8;
    localparam int PADW = MDW - (3 * CW + 27);

    plnpt_cmd_t  cmd;
    plnpt_stat_t st;

    logic [IDX_OUT_W-1:0] nearest_index;
    logic [HEAD_W-1:0]    heading;
    logic [CW-1:0]        near_x, near_y, near_z;
    logic                 query_error;

    plnpt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    plnpt_dp #(.MAX_POINTS(MAX_POINTS), .COORD_WIDTH(CW)) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_type      (s_tuser[0]),
        .restart_table (s_tuser[1]),
        .coord_x       (s_tdata[CW-1:0]),
        .coord_y       (s_tdata[2*CW-1:CW]),
        .coord_z       (s_tdata[3*CW-1:2*CW]),
        .hint_index    (s_tdata[3*CW+12:3*CW]),
        .window_steps  (s_tdata[3*CW+24:3*CW+13]),
        .cmd           (cmd),
        .st            (st),
        .m_tready      (m_tready),
        .m_tvalid      (m_tvalid),
        .nearest_index (nearest_index),
        .heading       (heading),
        .near_x        (near_x),
        .near_y        (near_y),
        .near_z        (near_z),
        .query_error   (query_error)
    );

    assign m_tdata    = {{PADW{1'b0}}, near_z, near_y, near_x, heading, nearest_index};
    assign m_tuser[0] = query_error;

endmodule
`default_nettype wire

// ----- test/polyline_nearest_point_checker.sv -----
`timescale 1ns / 1ps
module polyline_nearest_point_checker
    import plnpt_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    input  wire logic         s_tready,
    input  wire logic [103:0] s_tdata,
    input  wire logic [1:0]   s_tuser,
    input  wire logic         m_tvalid,
    input  wire logic         m_tready,
    input  wire logic [103:0] m_tdata,
    input  wire logic [0:0]   m_tuser,
    output int                errors,
    output int                outstanding
);

    localparam int TABLE_DEPTH = 4096;

    typedef struct {
        logic [11:0] idx;
        logic [14:0] head;
        logic [23:0] x;
        logic [23:0] y;
        logic [23:0] z;
        logic        err;
    } nearest_t;

    // arctan(2^-i) in 2^-14 degree
    localparam longint ATAN_STEP[CORDIC_STEPS] = '{
        737280, 435242, 229970, 116736, 58595, 29326, 14667, 7334, 3667, 1833,
        917, 458, 229, 115, 57, 29, 14, 7, 4, 2
    };

    int       pt_x[TABLE_DEPTH];
    int       pt_y[TABLE_DEPTH];
    int       pt_z[TABLE_DEPTH];
    int       pt_count;
    nearest_t nearest_q[$];

    function automatic longint dist_sq(int i, int qx, int qy, int qz);
        longint dx, dy, dz;
        dx = longint'(pt_x[i]) - qx;
        dy = longint'(pt_y[i]) - qy;
        dz = longint'(pt_z[i]) - qz;
        return dx * dx + dy * dy + dz * dz;
    endfunction

    function automatic int heading_toward(longint dx, longint dz);
        longint cx, cy, ang, xs, ys, v;
        cx = dx;
        cy = dz;
        ang = 0;
        if (dz == 0)
            return (dx < 0) ? HEAD_MAX : HEAD_EAST;
        if (dx == 0)
            return (dz > 0) ? HEAD_NORTH : HEAD_SOUTH;
        // fold the left half plane onto the right one
        if (dx < 0)
        begin
            cx = -dx;
            cy = -dz;
            ang = (dz > 0) ? DEG180 : -DEG180;
        end
        cx = cx <<< 20;
        cy = cy <<< 20;
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            xs = cx >>> i;
            ys = cy >>> i;
            if (cy > 0)
            begin
                cx = cx + ys;
                cy = cy - xs;
                ang = ang + ATAN_STEP[i];
            end
            else
            begin
                cx = cx - ys;
                cy = cy + xs;
                ang = ang - ATAN_STEP[i];
            end
        end
        v = ang + DEG180;
        if (v < 0)
            return 0;
        v = (v + 128) >>> 8;
        return (v > HEAD_MAX) ? HEAD_MAX : int'(v);
    endfunction

    function automatic nearest_t find_nearest(int qx, int qy, int qz, int hint, int win);
        nearest_t r;
        int       best, stop, first, nxt;
        longint   best_d, d;
        bit       have;
        r = '{default: '0};
        have = 0;
        best_d = 0;
        if (pt_count == 0 || hint < -1 || hint >= pt_count)
        begin
            r.err = 1'b1;
            return r;
        end
        if (hint == -1)
        begin
            best = 0;
            for (int i = 0; i < pt_count; i++)
            begin
                d = dist_sq(i, qx, qy, qz);
                if (!have || d < best_d)
                begin
                    have = 1;
                    best_d = d;
                    best = i;
                end
            end
        end
        else
        begin
            best = hint;
            stop = (hint + win > pt_count) ? pt_count : hint + win;
            for (int i = hint; i < stop; i++)
            begin
                d = dist_sq(i, qx, qy, qz);
                if (!have || d < best_d)
                begin
                    have = 1;
                    best_d = d;
                    best = i;
                end
            end
            first = (best > win) ? best - win : 0;
            stop = best;
            for (int i = first; i < stop; i++)
            begin
                d = dist_sq(i, qx, qy, qz);
                if (!have || d < best_d)
                begin
                    have = 1;
                    best_d = d;
                    best = i;
                end
            end
        end
        nxt = (best + 1 >= pt_count) ? 0 : best + 1;
        r.idx = best[11:0];
        r.head = 15'(heading_toward(longint'(pt_x[nxt]) - pt_x[best],
                                    longint'(pt_z[nxt]) - pt_z[best]));
        r.x = pt_x[best][23:0];
        r.y = pt_y[best][23:0];
        r.z = pt_z[best][23:0];
        return r;
    endfunction

    assign outstanding = nearest_q.size();

    initial
    begin
        errors = 0;
        pt_count = 0;
    end

    always @(posedge clk)
    begin
        nearest_t exp_r;
        int qx, qy, qz, hint, win;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (nearest_q.size() == 0)
                begin
                    $error("result transfer with no query outstanding");
                    errors++;
                end
                else
                begin
                    exp_r = nearest_q.pop_front();
                    if (m_tdata[11:0] !== exp_r.idx)
                    begin
                        $error("nearest_index expected %0d got %0d", exp_r.idx, m_tdata[11:0]);
                        errors++;
                    end
                    if (m_tdata[26:12] !== exp_r.head)
                    begin
                        $error("heading expected %0d got %0d", exp_r.head, m_tdata[26:12]);
                        errors++;
                    end
                    if (m_tdata[50:27] !== exp_r.x)
                    begin
                        $error("near_x expected %h got %h", exp_r.x, m_tdata[50:27]);
                        errors++;
                    end
                    if (m_tdata[74:51] !== exp_r.y)
                    begin
                        $error("near_y expected %h got %h", exp_r.y, m_tdata[74:51]);
                        errors++;
                    end
                    if (m_tdata[98:75] !== exp_r.z)
                    begin
                        $error("near_z expected %h got %h", exp_r.z, m_tdata[98:75]);
                        errors++;
                    end
                    if (m_tuser[0] !== exp_r.err)
                    begin
                        $error("query_error expected %0d got %0d", exp_r.err, m_tuser[0]);
                        errors++;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                qx = int'($signed(s_tdata[23:0]));
                qy = int'($signed(s_tdata[47:24]));
                qz = int'($signed(s_tdata[71:48]));
                hint = int'($signed(s_tdata[84:72]));
                win = int'(s_tdata[96:85]);
                if (s_tuser[0])
                    nearest_q.insert(nearest_q.size(), find_nearest(qx, qy, qz, hint, win));
                else
                begin
                    if (s_tuser[1])
                        pt_count = 0;
                    // drop the point when the table is full
                    if (pt_count < TABLE_DEPTH)
                    begin
                        pt_x[pt_count] = qx;
                        pt_y[pt_count] = qy;
                        pt_z[pt_count] = qz;
                        pt_count++;
                    end
                end
            end
        end
    end

endmodule

// ----- test/tb_polyline_nearest_point_tracker_top.sv -----
`timescale 1ns / 1ps
module tb_polyline_nearest_point_tracker_top;

    localparam bit APPEND = 1'b0;
    localparam bit QUERY  = 1'b1;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [103:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [103:0] m_tdata;
    logic [0:0]   m_tuser;
    int           errors;
    int           outstanding;
    int           send_idle;
    int           recv_idle;
    int           hold_len;
    int           npts;

    polyline_nearest_point_tracker_top uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    polyline_nearest_point_checker chk (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .errors(errors), .outstanding(outstanding)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    initial
    begin
        #50ms;
        $display("TEST FAILED");
        $finish;
    end

    // result side: long hold-off on request, else random stalls
    always @(negedge clk)
    begin
        if (hold_len > 0)
        begin
            m_tready <= 1'b0;
            hold_len = hold_len - 1;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_idle);
    end

    task automatic send_item(input bit qry, input bit restart, input logic [31:0] x,
                             input logic [31:0] y, input logic [31:0] z,
                             input logic [31:0] hint, input logic [31:0] win);
        @(negedge clk);
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= {restart, qry};
        s_tdata <= {7'd0, win[11:0], hint[12:0], z[23:0], y[23:0], x[23:0]};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (!qry)
            npts = restart ? 1 : ((npts < 4096) ? npts + 1 : npts);
    endtask

    function automatic int rand_coord();
        case ($urandom_range(3))
            0: return $urandom_range(8) - 4;
            1: return $urandom_range(2000) - 1000;
            default: return int'($urandom);
        endcase
    endfunction

    initial
    begin
        int r, hint, win;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        hold_len = 0;
        npts = 0;
        send_idle = 37;
        recv_idle = 54;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty table
        send_item(QUERY, 1'b0, 0, 0, 0, -1, 0);
        // headings: west, east, zero, south, and three of the four quadrants
        send_item(APPEND, 1'b1, 8388607, -8388608, 8388607, 0, 0);
        send_item(APPEND, 1'b0, -8388608, 8388607, 8388607, 0, 0);
        send_item(APPEND, 1'b0, 8388607, 0, 8388607, 0, 0);
        send_item(APPEND, 1'b0, 8388607, 0, 8388607, 0, 0);
        send_item(APPEND, 1'b0, 8388607, 0, -8388608, 0, 0);
        send_item(APPEND, 1'b0, 100, 5, -100, 0, 0);
        send_item(APPEND, 1'b0, -300, 5, 77, 0, 0);
        send_item(APPEND, 1'b0, 1000, 5, 1, 0, 0);
        for (int i = 0; i < 8; i++)
            send_item(QUERY, 1'b1, 0, 0, 0, i, 0);
        send_item(QUERY, 1'b0, 0, 0, 0, -1, 4095);
        send_item(QUERY, 1'b0, -300, 5, 77, 0, 4095);
        send_item(QUERY, 1'b0, 8388607, 0, 8388607, 7, 2);
        send_item(QUERY, 1'b0, 0, 0, 0, 8, 1);
        send_item(QUERY, 1'b0, 0, 0, 0, -4096, 1);
        send_item(QUERY, 1'b0, 0, 0, 0, 4095, 4095);

        for (int i = 0; i < 120; i++)
        begin
            if (i == 40)
            begin
                send_idle = 54;
                recv_idle = 37;
            end
            if (i == 80)
            begin
                send_idle = 0;
                recv_idle = 0;
                hold_len = 400;
            end
            r = $urandom_range(99);
            if (npts < 2 || r < 35 || i == 0)
                send_item(APPEND, (i == 0) || r < 3 || npts >= 40,
                          rand_coord(), rand_coord(), rand_coord(),
                          $urandom_range(8191), $urandom_range(4095));
            else
            begin
                r = $urandom_range(99);
                if (r < 20)
                    hint = -1;
                else if (r < 25)
                    hint = npts + $urandom_range(3);
                else if (r < 30)
                    hint = -$urandom_range(4096, 2);
                else
                    hint = $urandom_range(npts - 1);
                win = ($urandom_range(9) == 0) ? $urandom_range(4095) : $urandom_range(8);
                send_item(QUERY, $urandom_range(1), rand_coord(), rand_coord(), rand_coord(),
                          hint, win);
            end
        end
        @(negedge clk);
        s_tvalid <= 1'b0;

        while (outstanding != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
